// File: rtl/fgn3d_pkg.sv
// Shared types, constants and lookup tables for the fractal gradient noise block.
package fgn3d_pkg;

   localparam int COORD_W   = 32;
   localparam int NOISE_W   = 18;
   localparam int OCT_W     = 4;
   localparam int PERS_W    = 18;
   localparam int PERS_FRAC = 16;
   localparam int AMP_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE  = 2'd1;

   localparam logic [OCT_W-1:0]  OCTAVE_COUNT_RESET = 4'd4;
   localparam logic [PERS_W-1:0] PERSISTENCE_RESET  = 18'd32768;

   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN_MAG = 131072;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_HASH,
      ST_FADE,
      ST_LERP,
      ST_ACC0,
      ST_ACC1,
      ST_PREP,
      ST_DIV,
      ST_DONE
   } state_type;

   // blend weight selector
   typedef enum logic [1:0] {
      T_U,
      T_V,
      T_W
   } tsel_type;

   typedef struct packed {
      logic [3:0] src_a;
      logic [3:0] src_b;
      logic [3:0] dst;
      tsel_type   tsel;
   } lerp_ctl_type;

   // Corners sit at 0..7 (x bit 0, y bit 1, z bit 2), blends at 8..14.
   function automatic lerp_ctl_type lerp_ctl(input logic [2:0] idx);
      lerp_ctl_type c;
      c = '{src_a: 4'd0, src_b: 4'd1, dst: 4'd8, tsel: T_U};
      unique case (idx)
         3'd0: c = '{src_a: 4'd0,  src_b: 4'd1,  dst: 4'd8,  tsel: T_U};
         3'd1: c = '{src_a: 4'd2,  src_b: 4'd3,  dst: 4'd9,  tsel: T_U};
         3'd2: c = '{src_a: 4'd8,  src_b: 4'd9,  dst: 4'd10, tsel: T_V};
         3'd3: c = '{src_a: 4'd4,  src_b: 4'd5,  dst: 4'd11, tsel: T_U};
         3'd4: c = '{src_a: 4'd6,  src_b: 4'd7,  dst: 4'd12, tsel: T_U};
         3'd5: c = '{src_a: 4'd11, src_b: 4'd12, dst: 4'd13, tsel: T_V};
         3'd6: c = '{src_a: 4'd10, src_b: 4'd13, dst: 4'd14, tsel: T_W};
         default: c = '{src_a: 4'd10, src_b: 4'd13, dst: 4'd14, tsel: T_W};
      endcase
      return c;
   endfunction

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
      8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
      8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
      8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
      8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
      8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
      8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
      8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
      8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
      8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
      8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
      8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
      8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
      8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,
      8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,
      8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,
      8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,
      8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,
      8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
      8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

endpackage

// File: rtl/fractal_gradient_noise_3d.sv
// Fractal improved gradient noise over octaves, sequenced around a hash ROM and a node RAM.
//
//  channel   direction  handshake               payload
//  request   in         start & !busy           req_coord_x/y/z (signed, FRAC_BITS frac)
//  response  out        rsp_valid, one cycle    rsp_noise_value (signed Q2.FRAC_BITS)
//  csr       in         csr_valid & csr_ready   csr_index, csr_wdata
//
//  Each octave runs setup, hash ROM reads, fade, blend through the node RAM port and
//  accumulate; then come a prep step, the final division at one quotient bit per cycle
//  over DIV_W quotient bits (56 by default), and the done state; busy stays high throughout.
//  The result strobe lasts one cycle; the next start is taken the cycle after.
//  Reset is synchronous and restores the control state and the csr defaults.
//  The receiver cannot stall; csr_ready is always high.
module fractal_gradient_noise_3d #(
   parameter int MAX_OCTAVES = 8,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [fgn3d_pkg::COORD_W-1:0]     req_coord_x,
   input  logic signed [fgn3d_pkg::COORD_W-1:0]     req_coord_y,
   input  logic signed [fgn3d_pkg::COORD_W-1:0]     req_coord_z,
   output logic                                     rsp_valid,
   output logic signed [fgn3d_pkg::NOISE_W-1:0]     rsp_noise_value,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [fgn3d_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [fgn3d_pkg::CSR_DAT_W-1:0]          csr_wdata
);
   import fgn3d_pkg::*;

   localparam int FB    = FRAC_BITS;
   localparam int GW    = FB + 3;                 // gradients and blends
   localparam int MAW   = FB + 2;
   localparam int MBW   = FB + 5;
   localparam int MPW   = MAW + MBW;
   localparam int QW    = FB + 6;
   localparam int OCW   = $clog2(MAX_OCTAVES + 1);
   localparam int WPW   = GW + AMP_W + 1;
   localparam int PPW   = AMP_W + PERS_W;
   localparam int DIV_W = WPW + OCW;              // weighted total
   localparam int WSW   = AMP_W + OCW;            // weight sum
   localparam int STW   = ($clog2(DIV_W) > 5) ? $clog2(DIV_W) : 5;

   function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                 input logic signed [GW-1:0] x,
                                                 input logic signed [GW-1:0] y,
                                                 input logic signed [GW-1:0] z);
      logic signed [GW-1:0] r;
      r = '0;
      unique case (h)
         4'h0: r = x + y;
         4'h1: r = -x + y;
         4'h2: r = x - y;
         4'h3: r = -x - y;
         4'h4: r = x + z;
         4'h5: r = -x + z;
         4'h6: r = x - z;
         4'h7: r = -x - z;
         4'h8: r = y + z;
         4'h9: r = -y + z;
         4'hA: r = y - z;
         4'hB: r = -y - z;
         4'hC: r = y + x;
         4'hD: r = -y + z;
         4'hE: r = y - x;
         4'hF: r = -y - z;
         default: r = '0;
      endcase
      return r;
   endfunction

   state_type state_ff, state_in;

   logic [OCT_W-1:0]  octave_count_ff;
   logic [PERS_W-1:0] persistence_ff;

   logic [STW-1:0]          step_ff;
   logic [OCW-1:0]          oct_ff, n_eff_ff, n_eff;
   logic [COORD_W-1:0]      coord_x_ff, coord_y_ff, coord_z_ff;
   logic [7:0]              cx_ff, cy_ff, cz_ff;
   logic [FB-1:0]           fx_ff, fy_ff, fz_ff;
   logic [7:0]              a_ff, b_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic [FB:0]             fade_ff [3];
   logic [FB+3:0]           q_ff;
   logic signed [MPW-1:0]   mul_ff;
   logic signed [GW-1:0]    la_ff, nv_ff;
   logic signed [WPW-1:0]   wprod_ff;
   logic [PPW-1:0]          pprod_ff;
   logic [AMP_W-1:0]        amp_ff;
   logic [WSW-1:0]          wsum_ff;
   logic signed [DIV_W-1:0] total_ff;
   logic [DIV_W-1:0]        quo_ff;
   logic [WSW-1:0]          rem_ff;
   logic                    neg_ff;

   // hash ROM, registered read
   logic [7:0] rom_addr, rom_q_ff;
   // node RAM: corner gradients and blend results
   logic signed [GW-1:0] node_mem [16];
   logic signed [GW-1:0] mem_q_ff, mem_wd;
   logic [3:0]           mem_ra, mem_wa;
   logic                 mem_we;

   logic [COORD_W-1:0]   shx, shy, shz;
   logic [2:0]           leaf, corner;
   logic [7:0]           leaf_base;
   logic [1:0]           fsel;
   logic [1:0]           sub;
   lerp_ctl_type         lctl;
   logic [FB-1:0]        t_sel, t2;
   logic [QW-1:0]        q_pos, q_neg;
   logic signed [MAW-1:0] ma;
   logic signed [MBW-1:0] mb;
   logic signed [GW-1:0] gx, gy, gz;
   logic signed [GW:0]   ldiff, lsum;
   logic [FB:0]          fade_pick;
   logic [WSW:0]         trial;
   logic                 take;
   logic [DIV_W-1:0]     abs_total;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_count_ff <= OCTAVE_COUNT_RESET;
         persistence_ff  <= PERSISTENCE_RESET;
      end else if (csr_valid && csr_ready) begin
         priority case (csr_index)
            CSR_OCTAVE_COUNT: octave_count_ff <= csr_wdata[OCT_W-1:0];
            CSR_PERSISTENCE:  persistence_ff  <= csr_wdata[PERS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (octave_count_ff == '0) n_eff = OCW'(1);
      else if (32'(octave_count_ff) > MAX_OCTAVES) n_eff = OCW'(MAX_OCTAVES);
      else n_eff = OCW'(octave_count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_HASH;
         ST_HASH:  if (step_ff == STW'(14)) state_in = ST_FADE;
         ST_FADE:  if (step_ff == STW'(11)) state_in = ST_LERP;
         ST_LERP:  if (step_ff == STW'(27)) state_in = ST_ACC0;
         ST_ACC0:  state_in = ST_ACC1;
         ST_ACC1:  state_in = (oct_ff == n_eff_ff - OCW'(1)) ? ST_PREP : ST_SETUP;
         ST_PREP:  state_in = ST_DIV;
         ST_DIV:   if (step_ff == STW'(DIV_W - 1)) state_in = ST_DONE;
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= '0;
      else if (state_in != state_ff) step_ff <= '0;
      else step_ff <= step_ff + STW'(1);
   end

   assign shx = coord_x_ff << oct_ff;
   assign shy = coord_y_ff << oct_ff;
   assign shz = coord_z_ff << oct_ff;

   // hash read sequence
   assign leaf = 3'(step_ff - STW'(6));
   assign corner = 3'(step_ff - STW'(7));
   always_comb begin
      unique case (leaf[1:0])
         2'd0: leaf_base = aa_ff;
         2'd1: leaf_base = ba_ff;
         2'd2: leaf_base = ab_ff;
         2'd3: leaf_base = bb_ff;
         default: leaf_base = aa_ff;
      endcase
      priority case (step_ff)
         STW'(0): rom_addr = cx_ff;
         STW'(1): rom_addr = cx_ff + 8'd1;
         STW'(2): rom_addr = a_ff;
         STW'(3): rom_addr = a_ff + 8'd1;
         STW'(4): rom_addr = b_ff;
         STW'(5): rom_addr = b_ff + 8'd1;
         default: rom_addr = leaf_base + {7'd0, leaf[2]};
      endcase
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= PERM_ROM[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we) node_mem[mem_wa] <= mem_wd;
      mem_q_ff <= node_mem[mem_ra];
   end

   assign gx = corner[0] ? (GW'(fx_ff) - (GW'(1) <<< FB)) : GW'(fx_ff);
   assign gy = corner[1] ? (GW'(fy_ff) - (GW'(1) <<< FB)) : GW'(fy_ff);
   assign gz = corner[2] ? (GW'(fz_ff) - (GW'(1) <<< FB)) : GW'(fz_ff);

   assign fsel = step_ff[3:2];
   assign sub  = step_ff[1:0];
   assign lctl = lerp_ctl(step_ff[4:2]);
   assign t2   = mul_ff[2*FB-1:FB];

   always_comb begin
      unique case (fsel)
         2'd0: t_sel = fx_ff;
         2'd1: t_sel = fy_ff;
         default: t_sel = fz_ff;
      endcase
      unique case (lctl.tsel)
         T_U: fade_pick = fade_ff[0];
         T_V: fade_pick = fade_ff[1];
         default: fade_pick = fade_ff[2];
      endcase
   end

   assign q_pos = QW'(t2) * QW'(6) + (QW'(10) << FB);
   assign q_neg = QW'(t_sel) * QW'(15);
   assign ldiff = {mem_q_ff[GW-1], mem_q_ff} - {la_ff[GW-1], la_ff};
   assign lsum  = {la_ff[GW-1], la_ff} + mul_ff[FB+GW:FB];

   // shared multiplier operands and node RAM port controls
   always_comb begin
      ma = '0;
      mb = '0;
      mem_ra = lctl.src_a;
      mem_we = 1'b0;
      mem_wa = lctl.dst;
      mem_wd = lsum[GW-1:0];
      if (state_ff == ST_HASH && step_ff >= STW'(7)) begin
         mem_we = 1'b1;
         mem_wa = {1'b0, corner};
         mem_wd = grad(rom_q_ff[3:0], gx, gy, gz);
      end
      if (state_ff == ST_FADE) begin
         unique case (sub)
            2'd0: begin
               ma = MAW'(t_sel);
               mb = MBW'(t_sel);
            end
            2'd1: begin
               ma = MAW'(t2);
               mb = MBW'(t_sel);
            end
            2'd2: begin
               ma = MAW'(t2);
               mb = MBW'(q_ff);
            end
            default: ;
         endcase
      end
      if (state_ff == ST_LERP) begin
         unique case (sub)
            2'd0: mem_ra = lctl.src_a;
            2'd1: mem_ra = lctl.src_b;
            2'd2: begin
               ma = MAW'(fade_pick);
               mb = MBW'(ldiff);
            end
            default: mem_we = 1'b1;
         endcase
      end
   end

   assign abs_total = total_ff[DIV_W-1] ? DIV_W'(-total_ff) : DIV_W'(total_ff);
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign take  = (trial >= {1'b0, wsum_ff});

   always_ff @(posedge clock) begin
      mul_ff <= MPW'(ma * mb);
      unique case (state_ff)
         ST_IDLE: begin
            coord_x_ff <= req_coord_x;
            coord_y_ff <= req_coord_y;
            coord_z_ff <= req_coord_z;
            oct_ff     <= '0;
            n_eff_ff   <= n_eff;
            amp_ff     <= AMP_W'(1) << PERS_FRAC;
            wsum_ff    <= '0;
            total_ff   <= '0;
         end
         ST_SETUP: begin
            cx_ff <= shx[FB+7:FB];
            cy_ff <= shy[FB+7:FB];
            cz_ff <= shz[FB+7:FB];
            fx_ff <= shx[FB-1:0];
            fy_ff <= shy[FB-1:0];
            fz_ff <= shz[FB-1:0];
         end
         ST_HASH: begin
            priority case (step_ff)
               STW'(1): a_ff  <= rom_q_ff + cy_ff;
               STW'(2): b_ff  <= rom_q_ff + cy_ff;
               STW'(3): aa_ff <= rom_q_ff + cz_ff;
               STW'(4): ab_ff <= rom_q_ff + cz_ff;
               STW'(5): ba_ff <= rom_q_ff + cz_ff;
               STW'(6): bb_ff <= rom_q_ff + cz_ff;
               default: ;
            endcase
         end
         ST_FADE: begin
            if (sub == 2'd1) q_ff <= (q_pos >= q_neg) ? (FB+4)'(q_pos - q_neg) : '0;
            if (sub == 2'd3) fade_ff[fsel] <= mul_ff[2*FB:FB];
         end
         ST_LERP: begin
            if (sub == 2'd1) la_ff <= mem_q_ff;
            if (sub == 2'd3) nv_ff <= lsum[GW-1:0];
         end
         ST_ACC0: begin
            wprod_ff <= WPW'(nv_ff * $signed({1'b0, amp_ff}));
            pprod_ff <= amp_ff * persistence_ff;
         end
         ST_ACC1: begin
            total_ff <= total_ff + DIV_W'(wprod_ff);
            wsum_ff  <= wsum_ff + WSW'(amp_ff);
            amp_ff   <= (|pprod_ff[PPW-1:PERS_FRAC+AMP_W]) ? '1
                        : pprod_ff[PERS_FRAC+AMP_W-1:PERS_FRAC];
            oct_ff   <= oct_ff + OCW'(1);
         end
         ST_PREP: begin
            quo_ff <= abs_total;
            neg_ff <= total_ff[DIV_W-1];
            rem_ff <= '0;
         end
         ST_DIV: begin
            rem_ff <= take ? WSW'(trial - {1'b0, wsum_ff}) : trial[WSW-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], take};
         end
         default: ;
      endcase
   end

   // round toward zero, then clamp
   always_comb begin
      if (!neg_ff) begin
         if (quo_ff > DIV_W'(OUT_MAX)) rsp_noise_value = NOISE_W'(OUT_MAX);
         else rsp_noise_value = quo_ff[NOISE_W-1:0];
      end else begin
         if (quo_ff > DIV_W'(OUT_MIN_MAG)) rsp_noise_value = NOISE_W'(-OUT_MIN_MAG);
         else rsp_noise_value = -quo_ff[NOISE_W-1:0];
      end
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
   a_octave_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC1) |-> (oct_ff < n_eff_ff)) else $error("octave index overran");
   a_div_before_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == ST_DIV)) else $error("result without division");

endmodule
